FILE: rtl/core/dbmm_pkg.sv
`default_nettype none
package dbmm_pkg;

	// model input size and mosaic geometry
	localparam int MODEL_WIDTH    = 320;
	localparam int MODEL_HEIGHT   = 320;
	localparam int STREAMS        = 16;
	localparam int MAX_DETECTIONS = 64;
	localparam int MAX_BOXES      = 32;

	localparam int TILE_W   = 480;
	localparam int TILE_H   = 270;
	localparam int IMAGE_W  = 360;
	localparam int PAD_LEFT = 60;
	localparam int COL_W    = 2;   // four tile columns
	localparam int ROW_W    = 2;   // up to four tile rows

	localparam int MODEL_MAX = (MODEL_WIDTH > MODEL_HEIGHT) ? MODEL_WIDTH : MODEL_HEIGHT;

	// field widths
	localparam int FRAME_W = 32;
	localparam int BYTE_W  = 8;
	localparam int SRC_W   = 16;
	localparam int SCORE_W = 16;
	localparam int MAP_W   = 11;
	localparam int STAT_W  = 2;

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 120;
	localparam int OUT_USER_W = 3;

	// clamped corner, scaled numerator and quotient widths
	localparam int C_W   = $clog2(MODEL_MAX + 1);
	localparam int NUM_W = $clog2(MODEL_MAX * IMAGE_W + MODEL_MAX);
	localparam int Q_W   = $clog2(IMAGE_W + 1);

	// reciprocal constants for the divide by model size
	localparam int RCP_SHIFT = NUM_W + 2;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam int RCP_X     = (1 << RCP_SHIFT) / MODEL_WIDTH;
	localparam int RCP_Y     = (1 << RCP_SHIFT) / MODEL_HEIGHT;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_STREAM = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_COUNT  = 2'd2;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [Q_W-1:0]   quo_t;

	typedef struct packed {
		num_t x_min;
		num_t y_min;
		num_t x_max;
		num_t y_max;
	} num4_t;

	typedef struct packed {
		quo_t x_min;
		quo_t y_min;
		quo_t x_max;
		quo_t y_max;
	} quo4_t;

	// per-beat header and pass-through fields carried down the pipe
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FRAME_W-1:0] frame;
		logic [BYTE_W-1:0]  stream;
		logic [BYTE_W-1:0]  kept;
		logic               box;
		logic               last;
		logic [MAP_W-1:0]   x_org;
		logic [MAP_W-1:0]   y_org;
		logic [SCORE_W-1:0] score;
		logic [BYTE_W-1:0]  cls;
	} meta_t;

	// clamp a signed corner to 0..limit
	function automatic logic [C_W-1:0] clamp_corner(logic signed [SRC_W-1:0] v, int limit);
		logic [C_W-1:0] r;
		if (v <= 0) begin
			r = '0;
		end else if (v >= limit) begin
			r = C_W'(limit);
		end else begin
			r = v[C_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/detection_box_mosaic_mapper_top.sv
`default_nettype none
// maps detector boxes of up to 16 camera streams into a 4-column
// mosaic of 480x270 tiles (60-pixel left pad, 360x270 image per tile).
// one beat in is one box; it yields at most one beat out. the pipe takes
// a beat every cycle while the output side is not stalled and has three
// register stages: stage 1 decodes the header, clamps the corners and
// forms the scaled numerators, stage 2 holds the reciprocal products
// that divide by the model size, stage 3 corrects the quotients, adds
// the tile origin and is the output register. a stall on the output
// backs up through the stages without losing or repeating a beat. boxes
// past the kept count, and the non-first beats of a result with a bad
// stream or an excess count, are dropped at stage 1 and make no output
// beat. a result with count zero gives one header-only beat (tlast set,
// no box); an error result gives one beat with the status in tuser and
// tlast set.
module detection_box_mosaic_mapper_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// in_frame, in_stream, det_count, det_index, src_x_min, src_y_min,
	// src_x_max, src_y_max, src_score, src_class
	input  wire logic [dbmm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// out_frame, out_stream, kept_count, map_x_min, map_y_min, map_x_max,
	// map_y_max, out_score, out_class, zero pad
	output logic [dbmm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	// status, box_valid
	output logic [dbmm_pkg::OUT_USER_W-1:0]        m_axis_tuser,
	// last_box
	output logic                                   m_axis_tlast
);
	import dbmm_pkg::*;

	// input field unpacking
	logic [FRAME_W-1:0]      in_frame;
	logic [BYTE_W-1:0]       in_stream;
	logic [BYTE_W-1:0]       det_count;
	logic [BYTE_W-1:0]       det_index;
	logic signed [SRC_W-1:0] src_x_min;
	logic signed [SRC_W-1:0] src_y_min;
	logic signed [SRC_W-1:0] src_x_max;
	logic signed [SRC_W-1:0] src_y_max;
	logic [SCORE_W-1:0]      src_score;
	logic [BYTE_W-1:0]       src_class;

	assign in_frame  = s_axis_tdata[31:0];
	assign in_stream = s_axis_tdata[39:32];
	assign det_count = s_axis_tdata[47:40];
	assign det_index = s_axis_tdata[55:48];
	assign src_x_min = s_axis_tdata[71:56];
	assign src_y_min = s_axis_tdata[87:72];
	assign src_x_max = s_axis_tdata[103:88];
	assign src_y_max = s_axis_tdata[119:104];
	assign src_score = s_axis_tdata[135:120];
	assign src_class = s_axis_tdata[143:136];

	// pipe control: a stage moves when it is empty or the next one moves
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3          = !v_s3 || m_axis_tready;
	assign rdy2          = !v_s2 || rdy3;
	assign rdy1          = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	// header decode
	logic              bad_stream;
	logic              bad_count;
	logic [STAT_W-1:0] status_d;
	logic [BYTE_W-1:0] kept_d;
	logic              empty_d;
	logic              emit_d;
	logic              last_d;
	logic              box_d;
	meta_t             meta_d;

	always_comb begin
		bad_stream = in_stream >= BYTE_W'(STREAMS);
		bad_count  = det_count > BYTE_W'(MAX_DETECTIONS);
		if (bad_stream) begin
			status_d = STATUS_BAD_STREAM;
		end else if (bad_count) begin
			status_d = STATUS_BAD_COUNT;
		end else begin
			status_d = STATUS_OK;
		end
		kept_d  = (det_count < BYTE_W'(MAX_BOXES)) ? det_count : BYTE_W'(MAX_BOXES);
		empty_d = det_count == '0;

		if (status_d != STATUS_OK) begin
			// error is reported once, on the first box of the result
			emit_d = det_index == '0;
			last_d = 1'b1;
			box_d  = 1'b0;
		end else if (empty_d) begin
			// header-only result
			emit_d = 1'b1;
			last_d = 1'b1;
			box_d  = 1'b0;
		end else begin
			emit_d = det_index < kept_d;
			last_d = ({1'b0, det_index} + (BYTE_W+1)'(1)) == {1'b0, kept_d};
			box_d  = 1'b1;
		end

		meta_d.status = status_d;
		meta_d.frame  = in_frame;
		meta_d.stream = in_stream;
		meta_d.kept   = (status_d != STATUS_OK) ? '0 : kept_d;
		meta_d.box    = box_d;
		meta_d.last   = last_d;
		// tile origin: column from the low bits, row from the next ones
		meta_d.x_org  = MAP_W'(MAP_W'(in_stream[COL_W-1:0]) * MAP_W'(TILE_W))
			+ MAP_W'(PAD_LEFT);
		meta_d.y_org  = MAP_W'(MAP_W'(in_stream[COL_W +: ROW_W]) * MAP_W'(TILE_H));
		// score and class only travel with a mapped box
		meta_d.score  = box_d ? src_score : '0;
		meta_d.cls    = box_d ? src_class : '0;
	end

	// clamped corners scaled to the tile image, min floors and max ceils
	logic [C_W-1:0] cx_min, cy_min, cx_max, cy_max;
	num4_t          num_d;

	always_comb begin
		cx_min = clamp_corner(src_x_min, MODEL_WIDTH);
		cy_min = clamp_corner(src_y_min, MODEL_HEIGHT);
		cx_max = clamp_corner(src_x_max, MODEL_WIDTH);
		cy_max = clamp_corner(src_y_max, MODEL_HEIGHT);
		num_d.x_min = NUM_W'(NUM_W'(cx_min) * NUM_W'(IMAGE_W));
		num_d.y_min = NUM_W'(NUM_W'(cy_min) * NUM_W'(TILE_H));
		num_d.x_max = NUM_W'(NUM_W'(cx_max) * NUM_W'(IMAGE_W)) + NUM_W'(MODEL_WIDTH - 1);
		num_d.y_max = NUM_W'(NUM_W'(cy_max) * NUM_W'(TILE_H)) + NUM_W'(MODEL_HEIGHT - 1);
	end

	// stage 1
	meta_t meta_s1;
	num4_t num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_axis_tvalid && emit_d;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			meta_s1 <= meta_d;
			num_s1  <= num_d;
		end
	end

	// stage 2: reciprocal products live inside the scaler
	meta_t meta_s2;
	quo4_t quo;

	dbmm_scale u_scale (
		.clk (clk),
		.en  (rdy2),
		.num (num_s1),
		.quo (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			meta_s2 <= meta_s1;
		end
	end

	// stage 3: output register
	logic [MAP_W-1:0] mx_min_s3, my_min_s3, mx_max_s3, my_max_s3;
	meta_t            meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			meta_s3 <= meta_s2;
			if (meta_s2.box) begin
				mx_min_s3 <= meta_s2.x_org + MAP_W'(quo.x_min);
				my_min_s3 <= meta_s2.y_org + MAP_W'(quo.y_min);
				mx_max_s3 <= meta_s2.x_org + MAP_W'(quo.x_max);
				my_max_s3 <= meta_s2.y_org + MAP_W'(quo.y_max);
			end else begin
				mx_min_s3 <= '0;
				my_min_s3 <= '0;
				mx_max_s3 <= '0;
				my_max_s3 <= '0;
			end
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tlast  = meta_s3.last;
	assign m_axis_tuser  = {meta_s3.box, meta_s3.status};
	assign m_axis_tdata  = {4'b0, meta_s3.cls, meta_s3.score,
		my_max_s3, mx_max_s3, my_min_s3, mx_min_s3,
		meta_s3.kept, meta_s3.stream, meta_s3.frame};

	// a mapped box only comes with an ok status
	a_box_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STATUS_OK)
		else $error("mapped box with error status");

	// a beat without a box always closes its result
	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tlast)
		else $error("header or error beat without tlast");

	// mapped left edge never falls into the pad
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> mx_min_s3 >= MAP_W'(PAD_LEFT))
		else $error("mapped box left of the tile image");

	// kept count stays within the per-stream limit
	a_kept: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> meta_s2.kept <= BYTE_W'(MAX_BOXES))
		else $error("kept count above box limit");

endmodule
`default_nettype wire

FILE: rtl/core/dbmm_scale.sv
`default_nettype none
module dbmm_scale (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire dbmm_pkg::num4_t num,
	output dbmm_pkg::quo4_t    quo
);
	import dbmm_pkg::*;

	// estimated quotients, registered after the reciprocal multiply
	num4_t num_s2;
	quo4_t est_s2;
	quo4_t est_d;

	logic [NUM_W+RCP_W-1:0] px_min, py_min, px_max, py_max;

	assign px_min = (NUM_W+RCP_W)'(num.x_min) * (NUM_W+RCP_W)'(RCP_X);
	assign py_min = (NUM_W+RCP_W)'(num.y_min) * (NUM_W+RCP_W)'(RCP_Y);
	assign px_max = (NUM_W+RCP_W)'(num.x_max) * (NUM_W+RCP_W)'(RCP_X);
	assign py_max = (NUM_W+RCP_W)'(num.y_max) * (NUM_W+RCP_W)'(RCP_Y);

	always_comb begin
		est_d.x_min = px_min[RCP_SHIFT +: Q_W];
		est_d.y_min = py_min[RCP_SHIFT +: Q_W];
		est_d.x_max = px_max[RCP_SHIFT +: Q_W];
		est_d.y_max = py_max[RCP_SHIFT +: Q_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= num;
			est_s2 <= est_d;
		end
	end

	// estimate is exact or one low: fix with one remainder compare
	function automatic quo_t fix_quo(num_t n, quo_t q, int d);
		num_t qd;
		num_t r;
		quo_t res;
		qd = NUM_W'(NUM_W'(q) * NUM_W'(d));
		r  = n - qd;
		if (r >= NUM_W'(d)) begin
			res = q + Q_W'(1);
		end else begin
			res = q;
		end
		return res;
	endfunction

	always_comb begin
		quo.x_min = fix_quo(num_s2.x_min, est_s2.x_min, MODEL_WIDTH);
		quo.y_min = fix_quo(num_s2.y_min, est_s2.y_min, MODEL_HEIGHT);
		quo.x_max = fix_quo(num_s2.x_max, est_s2.x_max, MODEL_WIDTH);
		quo.y_max = fix_quo(num_s2.y_max, est_s2.y_max, MODEL_HEIGHT);
	end

endmodule
`default_nettype wire
